[hdl/prb_pkg.sv]
// Shared types, widths and codes of the priority RGB LED blinker.
`timescale 1ns / 1ps

package prb_pkg;

  localparam int unsigned SlotW   = 2;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ModeW   = 2;

  // Slot codes: three real slots at most, code 3 means nothing shown.
  localparam int unsigned MaxSlots    = 3;
  localparam int unsigned NumSlotsDef = 3;

  localparam logic [SlotW-1:0] ShownNone     = 2'd3;
  localparam logic [SlotW-1:0] SlotAttention = 2'd2;

  localparam logic OpSet  = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [ModeW-1:0] ModeNone     = 2'd0;
  localparam logic [ModeW-1:0] ModeTimed    = 2'd1;
  localparam logic [ModeW-1:0] ModeHardware = 2'd2;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusBadSlot = 2'd1;
  localparam logic [StatusW-1:0] StatusNoLed   = 2'd2;

  typedef struct packed {
    logic              op;
    logic [SlotW-1:0]  slot;
    logic [ColorW-1:0] color;
    logic [ModeW-1:0]  flash_mode;
    logic [TimeW-1:0]  on_time;
    logic [TimeW-1:0]  off_time;
  } item_t;

  typedef struct packed {
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

[hdl/prb_if.sv]
// Channel interfaces of the priority RGB LED blinker: items, results and configuration.
`timescale 1ns / 1ps

interface prb_item_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [prb_pkg::SlotW-1:0]   slot;
  logic [prb_pkg::ColorW-1:0]  color;
  logic [prb_pkg::ModeW-1:0]   flash_mode;
  logic [prb_pkg::TimeW-1:0]   on_time;
  logic [prb_pkg::TimeW-1:0]   off_time;

  modport source (output valid, op, slot, color, flash_mode, on_time, off_time,
                  input ready);
  modport sink (input valid, op, slot, color, flash_mode, on_time, off_time,
                output ready);
endinterface

interface prb_result_if;
  logic                         valid;
  logic                         ready;
  logic [prb_pkg::ChanW-1:0]    red;
  logic [prb_pkg::ChanW-1:0]    green;
  logic [prb_pkg::ChanW-1:0]    blue;
  logic [prb_pkg::StatusW-1:0]  status;

  modport source (output valid, red, green, blue, status, input ready);
  modport sink (input valid, red, green, blue, status, output ready);
endinterface

interface prb_cfg_if;
  logic valid;
  logic ready;
  logic rgb_present;

  modport source (output valid, rgb_present, input ready);
  modport sink (input valid, rgb_present, output ready);
endinterface

[hdl/prb_core.sv]
// Slot store, display selection and blink timer of the priority RGB LED blinker.
`timescale 1ns / 1ps

module prb_core #(
  parameter int unsigned NumSlots = prb_pkg::NumSlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  prb_pkg::item_t   item_i,
  input  logic             rgb_present_i,
  output prb_pkg::result_t result_o
);

  localparam int unsigned Depth = (NumSlots < prb_pkg::MaxSlots) ? NumSlots
                                                                 : prb_pkg::MaxSlots;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [prb_pkg::ColorW-1:0] color_q [Depth];
  logic [prb_pkg::ColorW-1:0] color_d [Depth];
  logic [prb_pkg::TimeW-1:0]  on_q    [Depth];
  logic [prb_pkg::TimeW-1:0]  on_d    [Depth];
  logic [prb_pkg::TimeW-1:0]  off_q   [Depth];
  logic [prb_pkg::TimeW-1:0]  off_d   [Depth];
  logic [prb_pkg::SlotW-1:0]  shown_q, shown_d;
  logic                       blink_q, blink_d;
  logic                       off_phase_q, off_phase_d;
  logic [prb_pkg::TimeW-1:0]  elapsed_q, elapsed_d;

  logic                        slot_ok;
  logic [IdxW-1:0]             wr_idx, sh_idx, rd_idx;
  logic [prb_pkg::ColorW-1:0]  col_w, shown_color;
  logic [prb_pkg::ModeW-1:0]   mode_w;
  logic                        keep_times;
  logic [prb_pkg::TimeW-1:0]   on_w, off_w, dur, elapsed_inc;
  logic [prb_pkg::SlotW-1:0]   fb_slot;
  logic                        fb_blink;
  logic [prb_pkg::StatusW-1:0] status;

  always_comb begin
    slot_ok = item_i.slot < prb_pkg::SlotW'(Depth);
    wr_idx  = item_i.slot[IdxW-1:0];
    sh_idx  = shown_q[IdxW-1:0];

    // Attention slot rules: no mode clears it, a hardware blink without an off
    // time is shown solid.
    col_w  = item_i.color;
    mode_w = item_i.flash_mode;
    if (item_i.slot == prb_pkg::SlotAttention) begin
      if (item_i.flash_mode == prb_pkg::ModeNone) begin
        col_w = '0;
      end else if (item_i.flash_mode == prb_pkg::ModeHardware &&
                   item_i.on_time != '0 && item_i.off_time == '0) begin
        mode_w = prb_pkg::ModeNone;
      end
    end
    keep_times = (mode_w == prb_pkg::ModeTimed) || (mode_w == prb_pkg::ModeHardware);
    on_w  = keep_times ? item_i.on_time  : '0;
    off_w = keep_times ? item_i.off_time : '0;

    // Highest lit slot below the one being cleared; later hits overwrite earlier ones.
    fb_slot  = prb_pkg::ShownNone;
    fb_blink = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      if (prb_pkg::SlotW'(i) < item_i.slot && color_q[i] != '0) begin
        fb_slot  = prb_pkg::SlotW'(i);
        fb_blink = (on_q[i] != '0) && (off_q[i] != '0);
      end
    end

    dur         = off_phase_q ? off_q[sh_idx] : on_q[sh_idx];
    elapsed_inc = elapsed_q + prb_pkg::TimeW'(1);

    color_d     = color_q;
    on_d        = on_q;
    off_d       = off_q;
    shown_d     = shown_q;
    blink_d     = blink_q;
    off_phase_d = off_phase_q;
    elapsed_d   = elapsed_q;
    status      = prb_pkg::StatusOk;

    if (fire_i) begin
      if (item_i.op == prb_pkg::OpSet) begin
        if (!slot_ok) begin
          status = prb_pkg::StatusBadSlot;
        end else if (!rgb_present_i) begin
          status = prb_pkg::StatusNoLed;
        end else begin
          color_d[wr_idx] = col_w;
          on_d[wr_idx]    = on_w;
          off_d[wr_idx]   = off_w;
          if (col_w != '0) begin
            if (shown_q == prb_pkg::ShownNone || item_i.slot >= shown_q) begin
              shown_d     = item_i.slot;
              blink_d     = (on_w != '0) && (off_w != '0);
              off_phase_d = 1'b0;
              elapsed_d   = '0;
            end
          end else if (item_i.slot == shown_q) begin
            shown_d     = fb_slot;
            blink_d     = fb_blink;
            off_phase_d = 1'b0;
            elapsed_d   = '0;
          end
        end
      end else if (blink_q) begin
        if (elapsed_inc >= dur) begin
          off_phase_d = !off_phase_q;
          elapsed_d   = '0;
        end else begin
          elapsed_d   = elapsed_inc;
        end
      end
    end

    rd_idx      = shown_d[IdxW-1:0];
    shown_color = '0;
    if (shown_d != prb_pkg::ShownNone && !(blink_d && off_phase_d)) begin
      shown_color = color_d[rd_idx];
    end
    result_o.red    = shown_color[23:16];
    result_o.green  = shown_color[15:8];
    result_o.blue   = shown_color[7:0];
    result_o.status = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        color_q[i] <= '0;
        on_q[i]    <= '0;
        off_q[i]   <= '0;
      end
      shown_q     <= prb_pkg::ShownNone;
      blink_q     <= 1'b0;
      off_phase_q <= 1'b0;
      elapsed_q   <= '0;
    end else begin
      color_q     <= color_d;
      on_q        <= on_d;
      off_q       <= off_d;
      shown_q     <= shown_d;
      blink_q     <= blink_d;
      off_phase_q <= off_phase_d;
      elapsed_q   <= elapsed_d;
    end
  end

  a_shown_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_q == prb_pkg::ShownNone || shown_q < prb_pkg::SlotW'(Depth))
    else $error("shown slot outside the supported slots");

  a_blink_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q |-> shown_q != prb_pkg::ShownNone)
    else $error("blinking with no slot shown");

  a_idle_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !blink_q |-> (!off_phase_q && elapsed_q == '0))
    else $error("blink timer not at rest while steady");

  a_tick_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.op == prb_pkg::OpTick) |=> shown_q == $past(shown_q))
    else $error("tick changed the shown slot");

endmodule

[hdl/priority_rgb_led_blinker.sv]
// Top level of the priority RGB LED blinker: input register, core and result register.
`timescale 1ns / 1ps

// The blinker drives one RGB LED shared by the battery, notification and
// attention slots, with the highest lit slot winning. Each accepted item is
// either a slot write or a one millisecond tick, and each produces exactly one
// result holding the LED drive levels after that item plus a status code.
// Items flow through an input register, a single pass of slot selection and
// blink timer logic, and a result register, so the block takes one item every
// clock cycle while results are taken; a result is offered once its item has
// passed the input register and the core. The core updates its slot state in
// the same cycle that the result enters the result register. A stalled result
// register holds the input register; an empty input register can still take
// another item while the result waits. The rgb_present register resets to one
// and should only be written while no item is in flight; its write channel is
// always ready.

module priority_rgb_led_blinker #(
  parameter int unsigned NumSlots = prb_pkg::NumSlotsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  prb_item_if.sink     in_i,
  prb_result_if.source out_o,
  prb_cfg_if.sink      cfg_i
);

  logic             rgb_present_q;
  logic             s1_valid_q;
  prb_pkg::item_t   s1_item_q;
  logic             out_valid_q;
  prb_pkg::result_t out_q;
  prb_pkg::result_t core_result;
  logic             advance;
  logic             fire;

  // The result register can take a new item when empty or being drained.
  assign advance     = !out_valid_q || out_o.ready;
  assign fire        = s1_valid_q && advance;
  assign in_i.ready  = !s1_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_present_q <= 1'b1;
    end else if (cfg_i.valid) begin
      rgb_present_q <= cfg_i.rgb_present;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.op         <= in_i.op;
      s1_item_q.slot       <= in_i.slot;
      s1_item_q.color      <= in_i.color;
      s1_item_q.flash_mode <= in_i.flash_mode;
      s1_item_q.on_time    <= in_i.on_time;
      s1_item_q.off_time   <= in_i.off_time;
    end
  end

  prb_core #(
    .NumSlots (NumSlots)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (s1_item_q),
    .rgb_present_i (rgb_present_q),
    .result_o      (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= core_result;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.red    = out_q.red;
  assign out_o.green  = out_q.green;
  assign out_o.blue   = out_q.blue;
  assign out_o.status = out_q.status;

endmodule
